// File: rtl/tve_pkg.sv
// Shared types and constants for the tilt vote / event alarm block.
// Used by tve_window, tve_out_buf and the top level; depends on nothing else.
package tve_pkg;

  localparam int PCT_FULL = 100;

  // Register indexes on the configuration port (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_VOTE_PERCENT  = 2'd0,
    REG_EVENTS_NEEDED = 2'd1,
    REG_HOLD_MS       = 2'd2,
    REG_SEQ_WINDOW_MS = 2'd3
  } reg_idx_t;

  localparam logic [6:0]  VOTE_PERCENT_RST  = 7'd80;
  localparam logic [7:0]  EVENTS_NEEDED_RST = 8'd3;
  localparam logic [31:0] HOLD_MS_RST       = 32'd5000;
  localparam logic [31:0] SEQ_WINDOW_MS_RST = 32'd10000;

  // Vote status handed from the window to the event logic
  typedef struct packed {
    logic full;
    logic level;
    logic undecided;
  } vote_t;

  // One result item
  typedef struct packed {
    logic       level_out;
    logic       send_alarm;
    logic [7:0] event_total;
    logic       alert_active;
    logic       tilt_detected;
  } res_t;

endpackage

// File: rtl/tve_cell.sv
// One sample cell of the window shift line.
// Depends on nothing; instantiated in a row by tve_window.
module tve_cell (
  input  logic clk,
  input  logic en,
  input  logic d,
  output logic q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end

endmodule

// File: rtl/tve_window.sv
// Sample window: a row of tve_cell plus running ones count, fill tracking and vote.
// Depends on tve_pkg and tve_cell.
module tve_window #(
  parameter int WINDOW_SAMPLES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift_en,
  input  logic             restart,
  input  logic             sample,
  input  logic [6:0]       vote_percent,
  output tve_pkg::vote_t   vote
);

  localparam int CW = $clog2(WINDOW_SAMPLES);
  localparam int OW = $clog2(WINDOW_SAMPLES + 1);

  logic [WINDOW_SAMPLES-1:0] tap;
  logic [CW-1:0]             fill_cnt;
  logic [CW-1:0]             fill_cnt_next;
  logic                      full;
  logic                      full_next;
  logic [OW-1:0]             ones;
  logic [OW-1:0]             ones_next;
  logic [6:0]                pct_tab [WINDOW_SAMPLES+1];
  logic [6:0]                pct1;
  logic [6:0]                pct0;
  logic                      win1;
  logic                      win0;

  for (genvar g = 0; g < WINDOW_SAMPLES; g++) begin : g_cell
    if (g == 0) begin : g_head
      tve_cell u_cell (.clk(clk), .en(shift_en), .d(sample), .q(tap[g]));
    end else begin : g_body
      tve_cell u_cell (.clk(clk), .en(shift_en), .d(tap[g-1]), .q(tap[g]));
    end
  end

  // Percentage of ones for every possible count
  for (genvar g = 0; g <= WINDOW_SAMPLES; g++) begin : g_pct
    localparam logic [6:0] PCT = 7'((g * tve_pkg::PCT_FULL) / WINDOW_SAMPLES);
    assign pct_tab[g] = PCT;
  end

  // While filling, the oldest cell still holds stale data: do not subtract it
  always_comb begin
    if (full) begin
      ones_next = ones + OW'(sample) - OW'(tap[WINDOW_SAMPLES-1]);
    end else begin
      ones_next = ones + OW'(sample);
    end
    full_next     = full | (fill_cnt == CW'(WINDOW_SAMPLES - 1));
    fill_cnt_next = full_next ? '0 : fill_cnt + CW'(1);
    pct1          = pct_tab[ones_next];
    pct0          = 7'(tve_pkg::PCT_FULL) - pct1;
    win1          = pct1 >= vote_percent;
    win0          = pct0 >= vote_percent;
    vote.full      = full_next;
    vote.level     = win1;
    vote.undecided = full_next & ~win1 & ~win0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt <= '0;
      full     <= 1'b0;
      ones     <= '0;
    end else if (shift_en) begin
      if (restart) begin
        fill_cnt <= '0;
        full     <= 1'b0;
        ones     <= '0;
      end else begin
        fill_cnt <= fill_cnt_next;
        full     <= full_next;
        ones     <= ones_next;
      end
    end
  end

endmodule

// File: rtl/tve_out_buf.sv
// Output register with one skid entry for result items.
// Depends on tve_pkg.
module tve_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tve_pkg::res_t in_res,
  output logic          out_valid,
  input  logic          out_ready,
  output tve_pkg::res_t out_res
);

  logic          skid_valid;
  tve_pkg::res_t skid_res;
  logic          push;
  logic          pop;

  assign in_ready = ~skid_valid;
  assign push     = in_valid & in_ready;
  assign pop      = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (push) begin
        if (!out_valid || pop) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (pop) begin
        // refill from the skid entry, or drain
        out_valid  <= skid_valid;
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!out_valid || pop) begin
        out_res <= in_res;
      end else begin
        skid_res <= in_res;
      end
    end else if (pop && skid_valid) begin
      out_res <= skid_res;
    end
  end

endmodule

// File: rtl/tilt_vote_event_alarm_top.sv
// Tilt vote / event alarm: one sample per transaction, one result per sample.
// Results are registered in the output register, or in the skid entry on a stall.
// Throughput: one item per cycle unless the output stalls; a skid entry keeps input
// open one item past a stalled output. Step logic around the cell row is combinational.
// Reset (synchronous, rst high) clears window fill, event and alert state,
// empties the output buffer and loads register defaults 80, 3, 5000, 10000.
module tilt_vote_event_alarm_top #(
  parameter int WINDOW_SAMPLES = 16
) (
  input  logic        clk,
  input  logic        rst,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [0] tilt_raw, [32:1] now_ms, [39:33] zero
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [0] tilt_detected, [1] alert_active,
                                 // [9:2] event_total, [10] send_alarm,
                                 // [11] level_out, [15:12] zero
);

  logic [6:0]  vote_percent;
  logic [7:0]  events_needed;
  logic [31:0] hold_ms;
  logic [31:0] seq_window_ms;

  logic        voted_level;
  logic        alert_on;
  logic [31:0] alert_since_ms;
  logic        alarm_sent;
  logic [7:0]  edge_count;
  logic [31:0] sequence_start_ms;

  logic        voted_level_next;
  logic        alert_on_next;
  logic [31:0] alert_since_ms_next;
  logic        alarm_sent_next;
  logic [7:0]  edge_count_next;
  logic [31:0] sequence_start_ms_next;

  logic          tilt_raw;
  logic [31:0]   now_ms;
  logic          accept;
  logic          cfg_wr;
  tve_pkg::reg_idx_t reg_sel;
  tve_pkg::vote_t    vote;
  tve_pkg::res_t     res;
  tve_pkg::res_t     out_res;

  logic        expire;
  logic        lvl;
  logic        fall;
  logic        first_edge;
  logic [7:0]  cnt_inc;
  logic [7:0]  cnt2;
  logic [31:0] start2;
  logic        overrun;
  logic        restart;
  logic        send;

  assign tilt_raw = s_tdata[0];
  assign now_ms   = s_tdata[32:1];
  assign accept   = s_tvalid & s_tready;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_sel = tve_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vote_percent  <= tve_pkg::VOTE_PERCENT_RST;
      events_needed <= tve_pkg::EVENTS_NEEDED_RST;
      hold_ms       <= tve_pkg::HOLD_MS_RST;
      seq_window_ms <= tve_pkg::SEQ_WINDOW_MS_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        tve_pkg::REG_VOTE_PERCENT:  vote_percent  <= pwdata[6:0];
        tve_pkg::REG_EVENTS_NEEDED: events_needed <= pwdata[7:0];
        tve_pkg::REG_HOLD_MS:       hold_ms       <= pwdata;
        tve_pkg::REG_SEQ_WINDOW_MS: seq_window_ms <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tve_pkg::REG_VOTE_PERCENT:  prdata = {25'd0, vote_percent};
      tve_pkg::REG_EVENTS_NEEDED: prdata = {24'd0, events_needed};
      tve_pkg::REG_HOLD_MS:       prdata = hold_ms;
      tve_pkg::REG_SEQ_WINDOW_MS: prdata = seq_window_ms;
      default:                    prdata = '0;
    endcase
  end

  tve_window #(
    .WINDOW_SAMPLES(WINDOW_SAMPLES)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .shift_en    (accept),
    .restart     (restart),
    .sample      (tilt_raw),
    .vote_percent(vote_percent),
    .vote        (vote)
  );

  // Step logic for one accepted sample
  always_comb begin
    expire = alert_on & ((now_ms - alert_since_ms) > hold_ms);
    alert_on_next       = alert_on & ~expire;
    alarm_sent_next     = alarm_sent & ~expire;
    alert_since_ms_next = alert_since_ms;
    send                = 1'b0;

    // an undecided vote restarts the sequence and counts no edge
    lvl        = vote.full ? vote.level : voted_level;
    fall       = voted_level & ~lvl & ~vote.undecided;
    first_edge = fall & (edge_count == 8'd0);
    cnt_inc    = edge_count + 8'd1;
    cnt2       = edge_count;
    start2     = first_edge ? now_ms : sequence_start_ms;

    if (fall) begin
      cnt2 = cnt_inc;
      if (cnt_inc >= events_needed) begin
        alert_on_next       = 1'b1;
        alert_since_ms_next = now_ms;
        send                = ~alarm_sent_next;
        alarm_sent_next     = 1'b1;
        cnt2                = 8'd0;
        start2              = '0;
      end
    end

    // a freshly started sequence has zero elapsed time, so only the old start matters
    overrun = (cnt2 != 8'd0) & ~first_edge &
              ((now_ms - sequence_start_ms) > seq_window_ms);
    restart = vote.undecided | overrun;

    if (vote.undecided) begin
      send = 1'b0;
    end

    voted_level_next       = restart ? 1'b0 : lvl;
    edge_count_next        = restart ? 8'd0 : cnt2;
    sequence_start_ms_next = restart ? '0 : start2;

    res.tilt_detected = fall & ~restart;
    res.alert_active  = alert_on_next;
    res.event_total   = edge_count_next;
    res.send_alarm    = send;
    res.level_out     = voted_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voted_level       <= 1'b0;
      alert_on          <= 1'b0;
      alert_since_ms    <= '0;
      alarm_sent        <= 1'b0;
      edge_count        <= 8'd0;
      sequence_start_ms <= '0;
    end else if (accept) begin
      voted_level       <= voted_level_next;
      alert_on          <= alert_on_next;
      alert_since_ms    <= alert_since_ms_next;
      alarm_sent        <= alarm_sent_next;
      edge_count        <= edge_count_next;
      sequence_start_ms <= sequence_start_ms_next;
    end
  end

  tve_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_res   (res),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_res  (out_res)
  );

  assign m_tdata = {4'd0, out_res};

endmodule

// File: rtl/tve_checker.sv
// Port-level checks for tilt_vote_event_alarm_top, attached with bind.
// Depends only on the top level's ports.
module tve_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // an alarm pulse always comes with the alert raised
  a_send_has_alert: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[10] |-> m_tdata[1])
    else $error("send_alarm without alert_active");

  // a counted falling edge leaves the voted level at zero
  a_edge_level_low: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !m_tdata[11])
    else $error("tilt_detected with level_out high");

  // reset empties the output buffer
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind tilt_vote_event_alarm_top tve_checker u_tve_checker (.*);
